@@ rtl/lism_pkg.sv @@
// package with item types and codes of the leveled interrupt status and mask unit
`timescale 1ns / 1ps
`default_nettype none
package lism_pkg;

    localparam int WORD_W    = 32;
    localparam int NORM_W    = 30;
    localparam int MASK_CNT  = 9;
    localparam int MASK_IDX_W = $clog2(MASK_CNT);
    localparam int CAT_CNT   = 3;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_LOWER = 2'd3
    } t_cmd;

    localparam logic [3:0] SEL_STAT_NORMAL = 4'd0;
    localparam logic [3:0] SEL_STAT_EXT    = 4'd1;
    localparam logic [3:0] SEL_STAT_ERR    = 4'd2;
    localparam logic [3:0] SEL_MASK_FIRST  = 4'd3;
    localparam logic [3:0] SEL_MASK_LAST   = 4'd11;

    localparam logic [1:0] CAT_NORMAL = 2'd0;
    localparam logic [1:0] CAT_EXT    = 2'd1;
    localparam logic [1:0] CAT_ERR    = 2'd2;

    typedef struct packed {
        t_cmd       command;
        logic [3:0] reg_select;
        logic [1:0] category;
        t_word      write_data;
        t_word      source_bits;
    } t_in_item;

    typedef struct packed {
        t_word read_data;
        logic  level9_request;
        logic  level11_request;
        logic  level13_request;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/lism_regs.sv @@
// status and mask registers with command decode and level request logic
`timescale 1ns / 1ps
`default_nettype none
module lism_regs
    import lism_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_in_item  i_item,
    output t_out_item      o_next
);

    logic [NORM_W-1:0] r_norm, n_norm;
    t_word             r_ext, n_ext;
    t_word             r_err, n_err;
    t_word             r_mask [MASK_CNT];
    t_word             n_mask [MASK_CNT];
    t_word             rdata;
    logic [MASK_IDX_W-1:0] mask_idx;
    logic              sel_mask;
    logic [CAT_CNT-1:0] lvl_hit;
    t_word             norm_word;

    assign mask_idx = MASK_IDX_W'(i_item.reg_select - SEL_MASK_FIRST);
    assign sel_mask = i_item.reg_select inside {[SEL_MASK_FIRST:SEL_MASK_LAST]};

    always_comb begin
        n_norm = r_norm;
        n_ext  = r_ext;
        n_err  = r_err;
        for (int k = 0; k < MASK_CNT; k++) begin
            n_mask[k] = r_mask[k];
        end
        rdata = '0;
        if (i_valid) begin
            case (i_item.command)
                CMD_READ: begin
                    case (i_item.reg_select)
                        SEL_STAT_NORMAL: rdata = {|r_err, |r_ext, r_norm};
                        SEL_STAT_EXT:    rdata = r_ext;
                        SEL_STAT_ERR:    rdata = r_err;
                        default: begin
                            if (sel_mask) begin
                                rdata = r_mask[mask_idx];
                            end
                        end
                    endcase
                end
                CMD_WRITE: begin
                    case (i_item.reg_select)
                        SEL_STAT_NORMAL: n_norm = r_norm & ~i_item.write_data[NORM_W-1:0];
                        SEL_STAT_EXT:    n_ext  = r_ext & ~i_item.write_data;
                        SEL_STAT_ERR:    n_err  = r_err & ~i_item.write_data;
                        default: begin
                            if (sel_mask) begin
                                n_mask[mask_idx] = i_item.write_data;
                            end
                        end
                    endcase
                end
                CMD_RAISE: begin
                    case (i_item.category)
                        CAT_NORMAL: n_norm = r_norm | i_item.source_bits[NORM_W-1:0];
                        CAT_EXT:    n_ext  = r_ext | i_item.source_bits;
                        CAT_ERR:    n_err  = r_err | i_item.source_bits;
                        default:    ;
                    endcase
                end
                CMD_LOWER: begin
                    case (i_item.category)
                        CAT_NORMAL: n_norm = r_norm & ~i_item.source_bits[NORM_W-1:0];
                        CAT_EXT:    n_ext  = r_ext & ~i_item.source_bits;
                        CAT_ERR:    n_err  = r_err & ~i_item.source_bits;
                        default:    ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // levels 2, 4, 6 use mask rows 0 to 2, 3 to 5 and 6 to 8
    assign norm_word = {{(WORD_W-NORM_W){1'b0}}, n_norm};

    always_comb begin
        for (int l = 0; l < CAT_CNT; l++) begin
            lvl_hit[l] = |((norm_word & n_mask[3*l])
                         | (n_ext & n_mask[3*l+1])
                         | (n_err & n_mask[3*l+2]));
        end
    end

    assign o_next.read_data       = rdata;
    assign o_next.level13_request = lvl_hit[0];
    assign o_next.level11_request = lvl_hit[1];
    assign o_next.level9_request  = lvl_hit[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= '0;
            r_ext  <= '0;
            r_err  <= '0;
            for (int k = 0; k < MASK_CNT; k++) begin
                r_mask[k] <= '0;
            end
        end else if (i_valid) begin
            r_norm <= n_norm;
            r_ext  <= n_ext;
            r_err  <= n_err;
            for (int k = 0; k < MASK_CNT; k++) begin
                r_mask[k] <= n_mask[k];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/leveled_interrupt_status_mask_unit.sv @@
// top level of the leveled interrupt status and mask unit
// result strobe o_done follows the transfer of a command through the registers r_in_valid and r_done
// throughput: one command per cycle, busy stays low in normal operation
// the result is shown for one cycle and the receiver cannot stall it
// reset: synchronous active low, clears status and masks to zero
// busy is high during reset and is cleared by the register r_busy once reset is released
`timescale 1ns / 1ps
`default_nettype none
module leveled_interrupt_status_mask_unit
    import lism_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_done,
    output t_out_item      o_result
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_done;
    t_out_item r_result;
    t_out_item n_result;
    logic      r_busy;

    lism_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in),
        .o_next  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
            r_busy     <= 1'b1;
        end else begin
            r_in_valid <= start && !r_busy;
            r_done     <= r_in_valid;
            r_busy     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= i_item;
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ rtl/lism_checker.sv @@
// port level checks of the leveled interrupt status and mask unit
`timescale 1ns / 1ps
`default_nettype none
module lism_checker
    import lism_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_in_item  i_item,
    input wire logic      o_done,
    input wire t_out_item o_result
);

    logic xfer;
    assign xfer = start && !busy;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> ##1 o_done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(xfer, 2))
        else $error("result without transfer");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(xfer && i_item.command != CMD_READ, 2))
            |-> o_result.read_data == '0)
        else $error("nonzero read data on non-read command");

endmodule

bind leveled_interrupt_status_mask_unit lism_checker u_chk (.*);
`default_nettype wire

@@ sim/leveled_interrupt_status_mask_unit_tb.sv @@
// self-checking testbench of the leveled interrupt status and mask unit
`timescale 1ns / 1ps
`default_nettype none
module leveled_interrupt_status_mask_unit_tb;
    import lism_pkg::*;

    localparam int N_RANDOM   = 1800;
    localparam int CALM_TAIL  = 150;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 8;
    localparam int L2_BASE    = 0;
    localparam int L4_BASE    = 3;
    localparam int L6_BASE    = 6;

    localparam logic [1:0] CAT_UNUSED = 2'd3;
    localparam logic [3:0] SEL_UNUSED_LAST = 4'd15;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    t_in_item  cmd_q[$];
    t_out_item irq_resp_q[$];
    t_out_item want;

    logic [NORM_W-1:0] normal_stat;
    t_word             ext_stat;
    t_word             err_stat;
    t_word             mask_word [MASK_CNT];

    int   n_total;
    int   n_sent;
    int   n_taken;
    int   n_errors;
    int   cycle_cnt;
    int   gap_left;
    int   gap_odds;
    logic took_last;

    leveled_interrupt_status_mask_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic level_hit(int base);
        return |(({2'b00, normal_stat} & mask_word[base])
                 | (ext_stat & mask_word[base + 1])
                 | (err_stat & mask_word[base + 2]));
    endfunction

    // updates the status and mask copy and returns what the unit must answer
    function automatic t_out_item apply_irq_command(t_in_item it);
        t_out_item r;
        logic      raise;
        r     = '0;
        raise = (it.command == CMD_RAISE);
        case (it.command)
            CMD_READ: begin
                if (it.reg_select == SEL_STAT_NORMAL)
                    r.read_data = {|err_stat, |ext_stat, normal_stat};
                else if (it.reg_select == SEL_STAT_EXT)
                    r.read_data = ext_stat;
                else if (it.reg_select == SEL_STAT_ERR)
                    r.read_data = err_stat;
                else if (it.reg_select <= SEL_MASK_LAST)
                    r.read_data = mask_word[it.reg_select - SEL_MASK_FIRST];
            end
            CMD_WRITE: begin
                if (it.reg_select == SEL_STAT_NORMAL)
                    normal_stat &= ~it.write_data[NORM_W-1:0];
                else if (it.reg_select == SEL_STAT_EXT)
                    ext_stat &= ~it.write_data;
                else if (it.reg_select == SEL_STAT_ERR)
                    err_stat &= ~it.write_data;
                else if (it.reg_select <= SEL_MASK_LAST)
                    mask_word[it.reg_select - SEL_MASK_FIRST] = it.write_data;
            end
            default: begin
                if (it.category == CAT_NORMAL)
                    normal_stat = raise ? normal_stat | it.source_bits[NORM_W-1:0]
                                        : normal_stat & ~it.source_bits[NORM_W-1:0];
                else if (it.category == CAT_EXT)
                    ext_stat = raise ? ext_stat | it.source_bits
                                     : ext_stat & ~it.source_bits;
                else if (it.category == CAT_ERR)
                    err_stat = raise ? err_stat | it.source_bits
                                     : err_stat & ~it.source_bits;
            end
        endcase
        r.level9_request  = level_hit(L6_BASE);
        r.level11_request = level_hit(L4_BASE);
        r.level13_request = level_hit(L2_BASE);
        return r;
    endfunction

    function automatic t_in_item mk_cmd(t_cmd c, logic [3:0] sel, logic [1:0] cat,
                                        t_word wd, t_word sb);
        t_in_item it;
        it.command     = c;
        it.reg_select  = sel;
        it.category    = cat;
        it.write_data  = wd;
        it.source_bits = sb;
        return it;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, WORD_W - 1);
            3: return $urandom() & $urandom() & $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_cmd();
        logic [3:0] sel;
        logic [1:0] cat;
        if ($urandom_range(0, 7) == 0)
            sel = 4'($urandom_range(int'(SEL_MASK_LAST) + 1, int'(SEL_UNUSED_LAST)));
        else
            sel = 4'($urandom_range(int'(SEL_STAT_NORMAL), int'(SEL_MASK_LAST)));
        if ($urandom_range(0, 9) == 0)
            cat = CAT_UNUSED;
        else
            cat = 2'($urandom_range(int'(CAT_NORMAL), int'(CAT_ERR)));
        return mk_cmd(t_cmd'($urandom_range(0, 3)), sel, cat, rand_word(), rand_word());
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !took_last)) begin
            if (gap_left == 0 && cmd_q.size() != 0 && n_sent < n_total - CALM_TAIL
                    && $urandom_range(0, 99) < gap_odds)
                gap_left = $urandom_range(1, 14);
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                i_item <= cmd_q.pop_front();
                start  <= 1'b1;
                n_sent++;
                if (n_sent % 128 == 0) begin
                    case ($urandom_range(0, 3))
                        0: gap_odds = 0;
                        1: gap_odds = 5;
                        2: gap_odds = 25;
                        default: gap_odds = 60;
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        cycle_cnt++;
        took_last <= i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            if (irq_resp_q.size() == 0) begin
                $error("result strobe with no transfer outstanding");
                n_errors++;
            end else begin
                want = irq_resp_q.pop_front();
                if (o_result.read_data !== want.read_data) begin
                    $error("read_data expected %h actual %h", want.read_data,
                           o_result.read_data);
                    n_errors++;
                end
                if (o_result.level9_request !== want.level9_request) begin
                    $error("level9_request expected %b actual %b", want.level9_request,
                           o_result.level9_request);
                    n_errors++;
                end
                if (o_result.level11_request !== want.level11_request) begin
                    $error("level11_request expected %b actual %b", want.level11_request,
                           o_result.level11_request);
                    n_errors++;
                end
                if (o_result.level13_request !== want.level13_request) begin
                    $error("level13_request expected %b actual %b", want.level13_request,
                           o_result.level13_request);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            irq_resp_q.push_back(apply_irq_command(i_item));
            n_taken++;
        end
        if (cycle_cnt > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        took_last   = 1'b0;
        normal_stat = '0;
        ext_stat    = '0;
        err_stat    = '0;
        foreach (mask_word[k]) mask_word[k] = '0;
        n_sent    = 0;
        n_taken   = 0;
        n_errors  = 0;
        cycle_cnt = 0;
        gap_left  = 0;
        gap_odds  = 0;

        // directed: extremes, summary bits, ignored bits and unused codes
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_STAT_NORMAL, CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_MASK_FIRST,  CAT_NORMAL, '1, '0));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_NORMAL, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_STAT_NORMAL, CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_EXT, '0, 32'h0000_0001));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_ERR, '0, 32'h8000_0000));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_STAT_NORMAL, CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_STAT_EXT,    CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_STAT_ERR,    CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_STAT_NORMAL, CAT_NORMAL, '1, '0));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_NORMAL, '0, 32'hc000_0000));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_UNUSED, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_LOWER, SEL_STAT_NORMAL, CAT_UNUSED, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_MASK_LAST,   CAT_NORMAL, '1, '0));
        cmd_q.push_back(mk_cmd(CMD_WRITE, 4'(int'(SEL_MASK_FIRST) + L4_BASE + 1),
                               CAT_NORMAL, 32'h0000_0001, '0));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_MASK_LAST,   CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_UNUSED_LAST, CAT_NORMAL, '1, '0));
        cmd_q.push_back(mk_cmd(CMD_READ,  SEL_UNUSED_LAST, CAT_NORMAL, '0, '0));
        cmd_q.push_back(mk_cmd(CMD_LOWER, SEL_STAT_NORMAL, CAT_EXT, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_STAT_ERR,    CAT_NORMAL, '1, '0));
        cmd_q.push_back(mk_cmd(CMD_RAISE, SEL_STAT_NORMAL, CAT_ERR, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_LOWER, SEL_STAT_NORMAL, CAT_ERR, '0, '1));
        cmd_q.push_back(mk_cmd(CMD_WRITE, SEL_MASK_LAST,   CAT_NORMAL, '0, '0));
        repeat (N_RANDOM) cmd_q.push_back(rand_cmd());
        n_total = cmd_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_taken == n_total);
        while (irq_resp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
